// ===== src/xcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// xcrd_pkg - shared types and constants of the character reference decoder
// Job format between the parser and the byte expander, reference kinds,
// the named entity table and the digit accumulate helper.
// ----------------------------------------------------------------------------
`default_nettype none

package xcrd_pkg;

  localparam int CODE_W     = 22;             // holds 0 .. CODE_LIMIT
  localparam int UCP_W      = 21;             // code point width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int NUM_ENT    = 5;

  localparam logic [CODE_W-1:0] CODE_LIMIT = 22'd2097152;

  localparam logic [7:0] CH_AMP  = 8'h26;     // '&'
  localparam logic [7:0] CH_SEMI = 8'h3B;     // ';'
  localparam logic [7:0] CH_HASH = 8'h23;     // '#'
  localparam logic [7:0] CH_LX   = 8'h78;     // 'x'
  localparam logic [7:0] CH_UX   = 8'h58;     // 'X'

  // lt, gt, amp, apos, quot
  localparam logic [7:0] ENT_NAME [NUM_ENT][4] = '{
    '{8'h6C, 8'h74, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h00, 8'h00},
    '{8'h61, 8'h6D, 8'h70, 8'h00},
    '{8'h61, 8'h70, 8'h6F, 8'h73},
    '{8'h71, 8'h75, 8'h6F, 8'h74}
  };
  localparam logic [3:0] ENT_LEN  [NUM_ENT] = '{4'd2, 4'd2, 4'd3, 4'd4, 4'd4};
  localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h3C, 8'h3E, 8'h26, 8'h27, 8'h22};

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_HASH  = 3'd1,
    KIND_DEC   = 3'd2,
    KIND_HEX   = 3'd3,
    KIND_NAMED = 3'd4,
    KIND_BAD   = 3'd5
  } ref_kind_t;

  typedef enum logic [1:0] {
    JOB_RAW  = 2'd0,   // one byte, taken as is
    JOB_CODE = 2'd1,   // code point, UTF-8 encoded
    JOB_ERR  = 2'd2    // dropped reference
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [UCP_W-1:0] code;
  } job_t;

  // value*base + digit, saturating at CODE_LIMIT
  function automatic logic [CODE_W-1:0] acc_digit(input logic [CODE_W-1:0] v,
                                                  input logic is_hex,
                                                  input logic [3:0] d);
    logic [CODE_W+3:0] wide;
    logic [CODE_W+3:0] v_ext;
    v_ext = {4'd0, v};
    if (is_hex) begin
      wide = (v_ext << 4) + {{CODE_W{1'b0}}, d};
    end else begin
      wide = (v_ext << 3) + (v_ext << 1) + {{CODE_W{1'b0}}, d};
    end
    if (wide >= {4'd0, CODE_LIMIT}) begin
      acc_digit = CODE_LIMIT;
    end else begin
      acc_digit = wide[CODE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/xcrd_front.sv =====
// ----------------------------------------------------------------------------
// xcrd_front - reference parser
// Takes one text byte a beat unless the job queue is full, tracks an open
// reference and pushes one job per result group into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrd_front
  import xcrd_pkg::*;
#(
  parameter int MAX_REF_SPAN = 9
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       job_full,
  output logic            job_push,
  output job_t            job
);

  localparam int OFF_W = $clog2(MAX_REF_SPAN + 1);
  localparam logic [OFF_W-1:0] SPAN = OFF_W'(MAX_REF_SPAN);

  logic              in_ref_r, in_ref_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  ref_kind_t         kind_r, kind_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              digit_r, digit_nxt;
  logic [4:0]        cand_r, cand_nxt;

  logic [OFF_W-1:0] off;
  logic [3:0]       off4;
  logic             acc;
  logic             is_dec, is_hexd;
  logic [3:0]       dval, hval;
  ref_kind_t        eff_kind;
  logic [4:0]       cand_upd;
  logic             nm_found;
  logic [7:0]       nm_char;

  assign acc  = in_push && !job_full;
  assign off  = off_r + OFF_W'(1);
  assign off4 = 4'(off);

  // digit decode
  always_comb begin
    is_dec  = (in_text_byte >= 8'h30) && (in_text_byte <= 8'h39);
    dval    = 4'(in_text_byte - 8'h30);
    is_hexd = 1'b1;
    hval    = dval;
    if (is_dec) begin
      hval = dval;
    end else if ((in_text_byte >= 8'h61) && (in_text_byte <= 8'h66)) begin
      hval = 4'(in_text_byte - 8'h57);
    end else if ((in_text_byte >= 8'h41) && (in_text_byte <= 8'h46)) begin
      hval = 4'(in_text_byte - 8'h37);
    end else begin
      is_hexd = 1'b0;
    end
  end

  // named candidate filter and end-of-name lookup
  always_comb begin
    cand_upd = cand_r;
    nm_found = 1'b0;
    nm_char  = 8'h00;
    for (int i = 0; i < NUM_ENT; i++) begin
      if (off4 > ENT_LEN[i]) begin
        cand_upd[i] = 1'b0;
      end else if (ENT_NAME[i][2'(off4 - 4'd1)] != in_text_byte) begin
        cand_upd[i] = 1'b0;
      end
    end
    for (int i = NUM_ENT - 1; i >= 0; i--) begin
      if (cand_r[i] && ((ENT_LEN[i] + 4'd1) == off4)) begin
        nm_found = 1'b1;
        nm_char  = ENT_CHAR[i];
      end
    end
  end

  always_comb begin
    in_ref_nxt = in_ref_r;
    off_nxt    = off_r;
    kind_nxt   = kind_r;
    code_nxt   = code_r;
    digit_nxt  = digit_r;
    cand_nxt   = cand_r;
    job_push   = 1'b0;
    job        = '{kind: JOB_RAW, code: '0};
    eff_kind   = (off == OFF_W'(1)) ? KIND_NAMED : kind_r;

    if (acc) begin
      if (!in_ref_r) begin
        if (in_text_byte == CH_AMP) begin
          in_ref_nxt = 1'b1;
          off_nxt    = '0;
          kind_nxt   = KIND_NONE;
          code_nxt   = '0;
          digit_nxt  = 1'b0;
          cand_nxt   = 5'h1F;
        end else begin
          job_push = 1'b1;
          job      = '{kind: JOB_RAW, code: UCP_W'(in_text_byte)};
        end
      end else if ((in_text_byte == CH_SEMI) || (off >= SPAN)) begin
        job_push = 1'b1;
        job      = '{kind: JOB_ERR, code: '0};
        if ((in_text_byte == CH_SEMI) && (off >= OFF_W'(3))) begin
          if (kind_r == KIND_NAMED) begin
            if (nm_found) begin
              job = '{kind: JOB_RAW, code: UCP_W'(nm_char)};
            end
          end else if (((kind_r == KIND_DEC) || (kind_r == KIND_HEX)) &&
                       digit_r && (code_r < CODE_LIMIT)) begin
            job = '{kind: JOB_CODE, code: code_r[UCP_W-1:0]};
          end
        end
        in_ref_nxt = 1'b0;
        off_nxt    = '0;
        kind_nxt   = KIND_NONE;
        code_nxt   = '0;
        digit_nxt  = 1'b0;
        cand_nxt   = 5'h1F;
      end else begin
        off_nxt = off;
        if ((off == OFF_W'(1)) && (in_text_byte == CH_HASH)) begin
          kind_nxt = KIND_HASH;
        end else begin
          case (eff_kind)
            KIND_HASH: begin
              if ((in_text_byte == CH_LX) || (in_text_byte == CH_UX)) begin
                kind_nxt = KIND_HEX;
              end else if (is_dec) begin
                kind_nxt  = KIND_DEC;
                code_nxt  = acc_digit(code_r, 1'b0, dval);
                digit_nxt = 1'b1;
              end else begin
                kind_nxt = KIND_BAD;
              end
            end
            KIND_DEC: begin
              if (is_dec) begin
                code_nxt  = acc_digit(code_r, 1'b0, dval);
                digit_nxt = 1'b1;
              end else begin
                kind_nxt = KIND_BAD;
              end
            end
            KIND_HEX: begin
              if (is_hexd) begin
                code_nxt  = acc_digit(code_r, 1'b1, hval);
                digit_nxt = 1'b1;
              end else begin
                kind_nxt = KIND_BAD;
              end
            end
            KIND_NAMED: begin
              cand_nxt = cand_upd;
              kind_nxt = (cand_upd == 5'h00) ? KIND_BAD : KIND_NAMED;
            end
            default: begin
              kind_nxt = KIND_BAD;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ref_r <= 1'b0;
      off_r    <= '0;
      kind_r   <= KIND_NONE;
      code_r   <= '0;
      digit_r  <= 1'b0;
      cand_r   <= 5'h1F;
    end else begin
      in_ref_r <= in_ref_nxt;
      off_r    <= off_nxt;
      kind_r   <= kind_nxt;
      code_r   <= code_nxt;
      digit_r  <= digit_nxt;
      cand_r   <= cand_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/xcrd_job_fifo.sv =====
// ----------------------------------------------------------------------------
// xcrd_job_fifo - short job queue between parser and expander
// First-word-fall-through register queue.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrd_job_fifo
  import xcrd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam logic [FIFO_AW:0] DEPTH = (FIFO_AW + 1)'(FIFO_DEPTH);

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == DEPTH);
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (FIFO_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/xcrd_back.sv =====
// ----------------------------------------------------------------------------
// xcrd_back - byte expander
// Holds the current job; hands out its 1 to 4 result bytes, one per out_pop.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrd_back
  import xcrd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_empty,
  input  wire logic  out_pop,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_bad_reference
);

  job_t       cur_r;
  logic [1:0] len_r;    // byte count minus one
  logic [1:0] idx_r;
  logic       vld_r;

  logic       advance, finish;
  logic [1:0] load_len;
  logic [UCP_W-1:0] v;

  assign advance   = vld_r && out_pop;
  assign finish    = advance && (idx_r == len_r);
  assign job_pop   = job_valid && (!vld_r || finish);
  assign out_empty = !vld_r;
  assign v         = cur_r.code;

  always_comb begin
    load_len = 2'd0;
    if (job.kind == JOB_CODE) begin
      if (job.code >= UCP_W'(65536)) begin
        load_len = 2'd3;
      end else if (job.code >= UCP_W'(2048)) begin
        load_len = 2'd2;
      end else if (job.code >= UCP_W'(128)) begin
        load_len = 2'd1;
      end
    end
  end

  always_comb begin
    out_last_of_run   = (idx_r == len_r);
    out_bad_reference = (cur_r.kind == JOB_ERR);
    out_byte          = v[7:0];
    case (cur_r.kind)
      JOB_ERR: out_byte = 8'h00;
      JOB_RAW: out_byte = v[7:0];
      JOB_CODE: begin
        case ({len_r, idx_r})
          4'b0000: out_byte = {1'b0, v[6:0]};
          4'b0100: out_byte = {3'b110, v[10:6]};
          4'b0101: out_byte = {2'b10, v[5:0]};
          4'b1000: out_byte = {4'b1110, v[15:12]};
          4'b1001: out_byte = {2'b10, v[11:6]};
          4'b1010: out_byte = {2'b10, v[5:0]};
          4'b1100: out_byte = {5'b11110, v[20:18]};
          4'b1101: out_byte = {2'b10, v[17:12]};
          4'b1110: out_byte = {2'b10, v[11:6]};
          4'b1111: out_byte = {2'b10, v[5:0]};
          default: out_byte = 8'h00;
        endcase
      end
      default: out_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r <= job;
      len_r <= load_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (job_pop) begin
      vld_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (finish) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (advance) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== src/xml_char_reference_decoder_core.sv =====
// ----------------------------------------------------------------------------
// xml_char_reference_decoder_core - XML character reference decoder
// Passes text bytes through and replaces named and numeric character
// references by their byte or UTF-8 sequence; bad references give one
// error result.
// ----------------------------------------------------------------------------
//
//  channel  handshake        payload
//  -------  ---------------  ----------------------------------------------
//  input    in_push/in_full  in_text_byte[7:0]
//  result   out_pop/out_empty out_byte[7:0], out_last_of_run, out_bad_reference
//
//  One text byte is taken every cycle while in_full is low.
//  A result reaches the ports through the job queue and then the expander's
//  current-job register; a decoded code point drains at one byte a cycle
//  while out_pop takes them, holding the expander until its last byte goes.
//  A four-job queue between parser and expander lets the parser keep taking
//  bytes while the result side is stalled; in_full rises only once it fills.
//  Synchronous active-low reset closes any open reference and empties the
//  queue; no clearing pass.
//
`default_nettype none

module xml_char_reference_decoder_core
  import xcrd_pkg::*;
#(
  parameter int MAX_REF_SPAN = 9      // 3 .. 15
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // text byte input
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_text_byte,
  // result output
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            out_bad_reference
);

  job_t f_job, h_job;
  logic f_push, q_full, h_valid, h_pop;

  // parser stalls only on a full job queue
  assign in_full = q_full;

  xcrd_front #(
    .MAX_REF_SPAN(MAX_REF_SPAN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_text_byte (in_text_byte),
    .job_full     (q_full),
    .job_push     (f_push),
    .job          (f_job)
  );

  xcrd_job_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_job   (f_job),
    .full       (q_full),
    .pop        (h_pop),
    .head_valid (h_valid),
    .head_job   (h_job)
  );

  // expander reloads in the beat its last byte is taken
  xcrd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (h_valid),
    .job               (h_job),
    .job_pop           (h_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_bad_reference (out_bad_reference)
  );

endmodule

`default_nettype wire
